>>> rtl/depth_pixel_unproject_to_world_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth pixel unprojection block.
// Two forms: a same-cycle implication and a next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_UNPROJECT_TO_WORLD_DEFINES_SVH
`define DEPTH_PIXEL_UNPROJECT_TO_WORLD_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPUW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPUW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dpuw_pkg.sv
// ----------------------------------------------------------------------------
// dpuw_pkg
// Widths, field offsets and register codes of the depth pixel unprojection.
// ----------------------------------------------------------------------------
`default_nettype none

package dpuw_pkg;

    // Coordinate bits that take part in the math, and the field width.
    localparam int PIXEL_COORD_BITS = 12;
    localparam int COORD_FIELD_W    = 12;
    localparam int COORD_USE_W      = (PIXEL_COORD_BITS < COORD_FIELD_W) ?
                                      PIXEL_COORD_BITS : COORD_FIELD_W;

    localparam int DEPTH_W = 16;
    localparam int CONF_W  = 16;
    localparam int COLOR_W = 24;
    localparam int INV_W   = 32;
    localparam int PP_W    = 16;
    localparam int ROT_W   = 16;
    localparam int TRANS_W = 21;
    localparam int OUT_W   = 32;

    // Input tdata layout, lowest bits first.
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + COORD_FIELD_W;
    localparam int DEPTH_LSB = ROW_LSB + COORD_FIELD_W;
    localparam int CONF_LSB  = DEPTH_LSB + DEPTH_W;
    localparam int COLOR_LSB = CONF_LSB + CONF_W;
    localparam int IN_DATA_W = ((COLOR_LSB + COLOR_W + 7) / 8) * 8;

    // Output tdata layout, lowest bits first.
    localparam int OUT_COLOR_LSB = 3 * OUT_W;
    localparam int OUT_DATA_W    = ((OUT_COLOR_LSB + COLOR_W + 7) / 8) * 8;

    // Datapath widths, all signed.
    localparam int DX_W    = ((COORD_USE_W + 4 > PP_W) ? COORD_USE_W + 4 : PP_W) + 1;
    localparam int PROD1_W = DX_W + INV_W + 1;
    localparam int N_W     = DX_W + 15;
    localparam int PROD2_W = N_W + DEPTH_W + 1;
    localparam int X_W     = N_W + 8;
    localparam int PROD3_W = X_W + ROT_W;
    localparam int ACC_W   = PROD3_W + 2;
    localparam int W_W     = ACC_W - 14;

    // 1.0e6 meters in Q.10.
    localparam longint WORLD_BOUND = 64'sd1024000000;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_TRANS,
        REG_INV_FOCAL,
        REG_PRINCIPAL,
        REG_CONF_THR
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/depth_pixel_unproject_to_world.sv
// ----------------------------------------------------------------------------
// depth_pixel_unproject_to_world
// Kept pixels pass stages 1 to 5 and the output register on to m_tvalid.
// One pixel per cycle unless stalled; six register stages with valid bits.
// A stalled output holds its stage; earlier bubbles still collapse behind it.
// Reset clears all valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_unproject_to_world (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dpuw_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dpuw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [dpuw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // Pixel input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pixel_column, pixel_row, depth_value, depth_confidence, pixel_color
    input  wire logic [dpuw_pkg::IN_DATA_W-1:0]    s_tdata,
    // sky_keep
    input  wire logic                              s_tuser,
    // Point output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // world_x, world_y, world_z, point_color
    output logic      [dpuw_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import dpuw_pkg::*;

    `include "depth_pixel_unproject_to_world_defines.svh"

    localparam logic signed [PROD1_W-1:0] RND18     = PROD1_W'(1) <<< 17;
    localparam logic signed [PROD2_W-1:0] RND10     = PROD2_W'(1) <<< 9;
    localparam logic signed [ACC_W-1:0]   RND14     = ACC_W'(1) <<< 13;
    localparam logic signed [W_W-1:0]     BOUND     = W_W'(WORLD_BOUND);
    localparam logic signed [OUT_W-1:0]   OUT_BOUND = OUT_W'(WORLD_BOUND);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3*ROT_W-1:0]   rot_reg [3];
    logic [3*TRANS_W-1:0] trans_reg;
    logic [2*INV_W-1:0]   inv_focal_reg;
    logic [2*PP_W-1:0]    pp_reg;
    logic [CONF_W-1:0]    conf_thr_reg;
    logic                 cfg_write;
    cfg_reg_t             cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]    <= '0;
            rot_reg[1]    <= '0;
            rot_reg[2]    <= '0;
            trans_reg     <= '0;
            inv_focal_reg <= '0;
            pp_reg        <= '0;
            conf_thr_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_ROT0:      rot_reg[0]    <= pwdata[3*ROT_W-1:0];
                REG_ROT1:      rot_reg[1]    <= pwdata[3*ROT_W-1:0];
                REG_ROT2:      rot_reg[2]    <= pwdata[3*ROT_W-1:0];
                REG_TRANS:     trans_reg     <= pwdata[3*TRANS_W-1:0];
                REG_INV_FOCAL: inv_focal_reg <= pwdata[2*INV_W-1:0];
                REG_PRINCIPAL: pp_reg        <= pwdata[2*PP_W-1:0];
                REG_CONF_THR:  conf_thr_reg  <= pwdata[CONF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_ROT0:      prdata = APB_DATA_W'(rot_reg[0]);
            REG_ROT1:      prdata = APB_DATA_W'(rot_reg[1]);
            REG_ROT2:      prdata = APB_DATA_W'(rot_reg[2]);
            REG_TRANS:     prdata = APB_DATA_W'(trans_reg);
            REG_INV_FOCAL: prdata = APB_DATA_W'(inv_focal_reg);
            REG_PRINCIPAL: prdata = APB_DATA_W'(pp_reg);
            REG_CONF_THR:  prdata = APB_DATA_W'(conf_thr_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !out_valid_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // ------------------------------------------------------------------
    // Stage 1: filter and offset from the principal point.
    // ------------------------------------------------------------------
    logic [COORD_USE_W-1:0] col_in, row_in;
    logic [DEPTH_W-1:0]     depth_in;
    logic [CONF_W-1:0]      conf_in;
    logic                   keep_in;
    logic signed [DX_W-1:0] dx_next, dy_next;
    logic signed [DX_W-1:0] dx1_reg, dy1_reg;
    logic [DEPTH_W-1:0]     depth1_reg, depth2_reg, depth3_reg;
    logic [COLOR_W-1:0]     color1_reg, color2_reg, color3_reg, color4_reg, color5_reg;

    assign col_in   = s_tdata[COL_LSB +: COORD_USE_W];
    assign row_in   = s_tdata[ROW_LSB +: COORD_USE_W];
    assign depth_in = s_tdata[DEPTH_LSB +: DEPTH_W];
    assign conf_in  = s_tdata[CONF_LSB +: CONF_W];
    assign keep_in  = (depth_in != '0) && (conf_in >= conf_thr_reg) && s_tuser;

    assign dx_next = $signed(DX_W'({col_in, 4'b0000})) - $signed(DX_W'(pp_reg[0 +: PP_W]));
    assign dy_next = $signed(DX_W'({row_in, 4'b0000})) - $signed(DX_W'(pp_reg[PP_W +: PP_W]));

    // ------------------------------------------------------------------
    // Stage 2: ray slope, offset times reciprocal focal length.
    // ------------------------------------------------------------------
    logic signed [PROD1_W-1:0] px_full, py_full, px_rnd, py_rnd;
    logic signed [N_W-1:0]     nx_next, ny_next, nx2_reg, ny2_reg;

    assign px_full = dx1_reg * $signed({1'b0, inv_focal_reg[0 +: INV_W]});
    assign py_full = dy1_reg * $signed({1'b0, inv_focal_reg[INV_W +: INV_W]});
    assign px_rnd  = px_full + RND18;
    assign py_rnd  = py_full + RND18;
    assign nx_next = N_W'(px_rnd >>> 18);
    assign ny_next = N_W'(py_rnd >>> 18);

    // ------------------------------------------------------------------
    // Stage 3: camera coordinates, slope times depth.
    // ------------------------------------------------------------------
    logic signed [PROD2_W-1:0] qx_full, qy_full, qx_rnd, qy_rnd;
    logic signed [X_W-1:0]     cam_next [3];
    logic signed [X_W-1:0]     cam3_reg [3];

    assign qx_full     = nx2_reg * $signed({1'b0, depth2_reg});
    assign qy_full     = ny2_reg * $signed({1'b0, depth2_reg});
    assign qx_rnd      = qx_full + RND10;
    assign qy_rnd      = qy_full + RND10;
    assign cam_next[0] = X_W'(qx_rnd >>> 10);
    assign cam_next[1] = X_W'(qy_rnd >>> 10);
    assign cam_next[2] = $signed(X_W'(depth2_reg));

    // ------------------------------------------------------------------
    // Stage 4: the nine rotation products.
    // ------------------------------------------------------------------
    logic signed [PROD3_W-1:0] prod_next [3][3];
    logic signed [PROD3_W-1:0] prod4_reg [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[r][k] = $signed(rot_reg[r][ROT_W*k +: ROT_W]) * cam3_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sum with translation and round to Q.10.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc   [3];
    logic signed [W_W-1:0]   w_next [3];
    logic signed [W_W-1:0]   w5_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = ACC_W'(prod4_reg[r][0]) + ACC_W'(prod4_reg[r][1])
                   + ACC_W'(prod4_reg[r][2])
                   + (ACC_W'($signed(trans_reg[TRANS_W*r +: TRANS_W])) <<< 14)
                   + RND14;
            w_next[r] = W_W'(acc[r] >>> 14);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: world bound check into the output register.
    // ------------------------------------------------------------------
    logic                  in_bound;
    logic [OUT_W-1:0]      world_reg [3];
    logic [COLOR_W-1:0]    point_color_reg;

    assign in_bound = (w5_reg[0] <= BOUND) && (w5_reg[0] >= -BOUND)
                   && (w5_reg[1] <= BOUND) && (w5_reg[1] >= -BOUND)
                   && (w5_reg[2] <= BOUND) && (w5_reg[2] >= -BOUND);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid && keep_in;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                out_valid_reg <= v5_reg && in_bound;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx1_reg    <= dx_next;
            dy1_reg    <= dy_next;
            depth1_reg <= depth_in;
            color1_reg <= s_tdata[COLOR_LSB +: COLOR_W];
        end
        if (rdy2)
        begin
            nx2_reg    <= nx_next;
            ny2_reg    <= ny_next;
            depth2_reg <= depth1_reg;
            color2_reg <= color1_reg;
        end
        if (rdy3)
        begin
            cam3_reg   <= cam_next;
            depth3_reg <= depth2_reg;
            color3_reg <= color2_reg;
        end
        if (rdy4)
        begin
            prod4_reg  <= prod_next;
            color4_reg <= color3_reg;
        end
        if (rdy5)
        begin
            w5_reg     <= w_next;
            color5_reg <= color4_reg;
        end
        if (rdy6)
        begin
            world_reg[0]    <= w5_reg[0][OUT_W-1:0];
            world_reg[1]    <= w5_reg[1][OUT_W-1:0];
            world_reg[2]    <= w5_reg[2][OUT_W-1:0];
            point_color_reg <= color5_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({point_color_reg, world_reg[2], world_reg[1], world_reg[0]});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DPUW_ASSERT_IMP(a_empty_out_accepts, clk, rst_n, !m_tvalid, s_tready, "stage chain blocked with empty output")
    `DPUW_ASSERT_NXT(a_zero_depth_dropped, clk, rst_n, s_tvalid && s_tready && (s_tdata[DEPTH_LSB +: DEPTH_W] == '0), !v1_reg, "zero-depth pixel entered the pipeline")
    `DPUW_ASSERT_IMP(a_out_in_bound, clk, rst_n, m_tvalid, ($signed(m_tdata[0 +: OUT_W]) <= OUT_BOUND) && ($signed(m_tdata[0 +: OUT_W]) >= -OUT_BOUND), "emitted world x beyond bound")
    `DPUW_ASSERT_NXT(a_stage3_holds, clk, rst_n, v3_reg && !rdy4, v3_reg && $stable(depth3_reg) && $stable(color3_reg), "stalled camera stage changed")

endmodule

`default_nettype wire

>>> dv/dpuw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpuw_checker
// Watches the register port and both pixel streams of the unprojection block.
// It keeps its own copy of the pose, focal and threshold registers, predicts
// the world point of every accepted pixel request, and compares each point
// that leaves the block, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dpuw_checker
    import dpuw_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    input  wire logic                    pready,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [IN_DATA_W-1:0]    s_tdata,
    input  wire logic                    s_tuser,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [OUT_DATA_W-1:0]   m_tdata,
    output int                           mismatches,
    output int                           points_pending
);

    typedef struct {
        logic [OUT_W-1:0]   x;
        logic [OUT_W-1:0]   y;
        logic [OUT_W-1:0]   z;
        logic [COLOR_W-1:0] color;
    } world_point_t;

    logic [3*ROT_W-1:0]   rot_row [3];
    logic [3*TRANS_W-1:0] trans_xyz;
    logic [2*INV_W-1:0]   inv_focal;
    logic [2*PP_W-1:0]    principal;
    logic [CONF_W-1:0]    conf_thr;

    world_point_t expected_points [$];
    int           fail_count = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    // Divide by 2^s, rounding half toward plus infinity.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Camera-space offset along one axis in Q.10 meters.
    function automatic longint ray_to_meters(input logic [COORD_FIELD_W-1:0] pix,
                                             input logic [PP_W-1:0] center,
                                             input logic [INV_W-1:0] recip,
                                             input logic [DEPTH_W-1:0] depth);
        longint offset;
        longint slope;
        // Coordinate bits above the used width take no part in the math.
        offset = longint'({pix[COORD_USE_W-1:0], 4'b0000}) - longint'(center);
        slope  = round_shift(offset * longint'(recip), 18);
        return round_shift(slope * longint'(depth), 10);
    endfunction

    function automatic longint world_coord(input int k, input longint cam_x,
                                           input longint cam_y, input longint cam_z);
        logic [3*ROT_W-1:0] row;
        longint             acc;
        row = rot_row[k];
        acc = longint'($signed(row[15:0])) * cam_x
            + longint'($signed(row[31:16])) * cam_y
            + longint'($signed(row[47:32])) * cam_z
            + longint'($signed(trans_xyz[TRANS_W*k +: TRANS_W])) * 64'sd16384;
        return round_shift(acc, 14);
    endfunction

    // Returns 1 when the pixel survives the filters and the world bound.
    function automatic bit unproject(input logic [IN_DATA_W-1:0] data, input logic keep,
                                     output world_point_t pt);
        logic [COORD_FIELD_W-1:0] col;
        logic [COORD_FIELD_W-1:0] row;
        logic [DEPTH_W-1:0]       depth;
        logic [CONF_W-1:0]        conf;
        longint                   cam_x;
        longint                   cam_y;
        longint                   w [3];
        int                       k;
        col   = data[COL_LSB +: COORD_FIELD_W];
        row   = data[ROW_LSB +: COORD_FIELD_W];
        depth = data[DEPTH_LSB +: DEPTH_W];
        conf  = data[CONF_LSB +: CONF_W];
        pt.color = data[COLOR_LSB +: COLOR_W];
        if (depth == '0 || conf < conf_thr || !keep)
            return 1'b0;
        cam_x = ray_to_meters(col, principal[PP_W-1:0], inv_focal[INV_W-1:0], depth);
        cam_y = ray_to_meters(row, principal[2*PP_W-1:PP_W], inv_focal[2*INV_W-1:INV_W],
                              depth);
        for (k = 0; k < 3; k++)
        begin
            w[k] = world_coord(k, cam_x, cam_y, longint'(depth));
            if (w[k] > WORLD_BOUND || w[k] < -WORLD_BOUND)
                return 1'b0;
        end
        pt.x = w[0][OUT_W-1:0];
        pt.y = w[1][OUT_W-1:0];
        pt.z = w[2][OUT_W-1:0];
        return 1'b1;
    endfunction

    task automatic compare_point(input logic [OUT_DATA_W-1:0] data);
        world_point_t want;
        logic [OUT_W-1:0]   got_x;
        logic [OUT_W-1:0]   got_y;
        logic [OUT_W-1:0]   got_z;
        logic [COLOR_W-1:0] got_color;
        got_x     = data[0 +: OUT_W];
        got_y     = data[OUT_W +: OUT_W];
        got_z     = data[2*OUT_W +: OUT_W];
        got_color = data[OUT_COLOR_LSB +: COLOR_W];
        if (expected_points.size() == 0)
        begin
            report_mismatch($sformatf("point %h with no pixel waiting for it", data));
            return;
        end
        want = expected_points.pop_front();
        if (got_x !== want.x)
            report_mismatch($sformatf("world_x got %0d expected %0d",
                                      $signed(got_x), $signed(want.x)));
        if (got_y !== want.y)
            report_mismatch($sformatf("world_y got %0d expected %0d",
                                      $signed(got_y), $signed(want.y)));
        if (got_z !== want.z)
            report_mismatch($sformatf("world_z got %0d expected %0d",
                                      $signed(got_z), $signed(want.z)));
        if (got_color !== want.color)
            report_mismatch($sformatf("point_color got %h expected %h",
                                      got_color, want.color));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        world_point_t pt;
        if (!rst_n)
        begin
            rot_row[0]  <= '0;
            rot_row[1]  <= '0;
            rot_row[2]  <= '0;
            trans_xyz   <= '0;
            inv_focal   <= '0;
            principal   <= '0;
            conf_thr    <= '0;
            expected_points.delete();
            points_pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_point(m_tdata);
            if (s_tvalid && s_tready)
            begin
                if (unproject(s_tdata, s_tuser, pt))
                    expected_points.insert(expected_points.size(), pt);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_ROT0:      rot_row[0] <= pwdata[3*ROT_W-1:0];
                    REG_ROT1:      rot_row[1] <= pwdata[3*ROT_W-1:0];
                    REG_ROT2:      rot_row[2] <= pwdata[3*ROT_W-1:0];
                    REG_TRANS:     trans_xyz  <= pwdata[3*TRANS_W-1:0];
                    REG_INV_FOCAL: inv_focal  <= pwdata[2*INV_W-1:0];
                    REG_PRINCIPAL: principal  <= pwdata[2*PP_W-1:0];
                    REG_CONF_THR:  conf_thr   <= pwdata[CONF_W-1:0];
                    default:       ;
                endcase
            end
            points_pending <= expected_points.size();
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives depth pixel requests and register writes into the unprojection
// block: a directed set of edge cases under several poses, then random pixels
// under random poses, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
    import dpuw_pkg::*;

    localparam logic [2:0]  UNUSED_REG   = 3'd7;
    localparam int          DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          PHASE_PIXELS = 200;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    wire  [APB_DATA_W-1:0]   prdata;
    wire                     pready;
    logic                    s_tvalid = 1'b0;
    wire                     s_tready;
    // pixel_column, pixel_row, depth_value, depth_confidence, pixel_color
    logic [IN_DATA_W-1:0]    s_tdata  = '0;
    // sky_keep
    logic                    s_tuser  = 1'b0;
    wire                     m_tvalid;
    logic                    m_tready = 1'b0;
    // world_x, world_y, world_z, point_color
    wire  [OUT_DATA_W-1:0]   m_tdata;

    int                      mismatches;
    int                      points_pending;
    int unsigned             cycle_count = 0;
    bit                      steady_flow = 1'b0;
    logic [CONF_W-1:0]       threshold_now = '0;

    depth_pixel_unproject_to_world uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dpuw_checker point_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .points_pending (points_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (m_tready && !steady_flow)
            begin
                m_tready <= 1'b0;
                hold = idle_length();
            end
            else
            begin
                m_tready <= 1'b1;
                hold = steady_flow ? 0 : $urandom_range(0, 24);
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_pixel(input logic [COORD_FIELD_W-1:0] col,
                                                        input logic [COORD_FIELD_W-1:0] row,
                                                        input logic [DEPTH_W-1:0] depth,
                                                        input logic [CONF_W-1:0] conf,
                                                        input logic [COLOR_W-1:0] color);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[COL_LSB +: COORD_FIELD_W]   = col;
        data[ROW_LSB +: COORD_FIELD_W]   = row;
        data[DEPTH_LSB +: DEPTH_W]       = depth;
        data[CONF_LSB +: CONF_W]         = conf;
        data[COLOR_LSB +: COLOR_W]       = color;
        return data;
    endfunction

    function automatic logic [ROT_W-1:0] random_coeff();
        return ROT_W'($urandom_range(0, 32768) - 16384);
    endfunction

    task automatic send_pixel(input logic [IN_DATA_W-1:0] data, input logic keep);
        int gap;
        gap = steady_flow ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= keep;
        do @(posedge clk); while (!s_tready);
    endtask

    // Holds the input off until every predicted point has left the block.
    task automatic wait_for_points();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index,
                                  input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_pose(input logic [3*ROT_W-1:0] rot0, input logic [3*ROT_W-1:0] rot1,
                              input logic [3*ROT_W-1:0] rot2,
                              input logic [3*TRANS_W-1:0] trans,
                              input logic [2*INV_W-1:0] inv, input logic [2*PP_W-1:0] pp,
                              input logic [CONF_W-1:0] thr);
        write_register(REG_ROT0, APB_DATA_W'(rot0));
        write_register(REG_ROT1, APB_DATA_W'(rot1));
        write_register(REG_ROT2, APB_DATA_W'(rot2));
        write_register(REG_TRANS, APB_DATA_W'(trans));
        write_register(REG_INV_FOCAL, APB_DATA_W'(inv));
        write_register(REG_PRINCIPAL, APB_DATA_W'(pp));
        write_register(REG_CONF_THR, APB_DATA_W'(thr));
        threshold_now = thr;
    endtask

    // A wild pose mostly throws points past the world bound; a plausible one keeps them.
    task automatic random_pose(input bit wild);
        if (wild)
            write_pose(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                       {$urandom, $urandom}, $urandom, 16'($urandom));
        else
            write_pose({random_coeff(), random_coeff(), random_coeff()},
                       {random_coeff(), random_coeff(), random_coeff()},
                       {random_coeff(), random_coeff(), random_coeff()},
                       63'({$urandom, $urandom}),
                       {32'($urandom_range(4096, 4194304)), 32'($urandom_range(4096, 4194304))},
                       $urandom, 16'($urandom_range(0, 16'h4000)));
    endtask

    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        logic [CONF_W-1:0]  conf;
        int                 pick;
        pick  = $urandom_range(0, 99);
        depth = (pick < 5) ? '0 :
                (pick < 20) ? DEPTH_W'($urandom_range(1, 255)) : DEPTH_W'($urandom);
        conf  = ($urandom_range(0, 9) == 0) ? threshold_now : CONF_W'($urandom);
        send_pixel(pack_pixel(12'($urandom), 12'($urandom), depth, conf, 24'($urandom)),
                   $urandom_range(0, 9) != 0);
    endtask

    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: zero reciprocal focal and zero pose put every kept
        // point at the origin, and a zero confidence still meets a zero threshold.
        send_pixel(pack_pixel(12'd1, 12'd2, 16'd3, 16'd0, 24'h000001), 1'b1);
        send_pixel(pack_pixel(12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 24'hFFFFFF), 1'b1);
        send_pixel(pack_pixel(12'd7, 12'd9, 16'd0, 16'hFFFF, 24'h00FF00), 1'b1);
        send_pixel(pack_pixel(12'd7, 12'd9, 16'd512, 16'hFFFF, 24'h0000FF), 1'b0);
        wait_for_points();

        // Identity rotation, offset camera, focal near 525 pixels.
        write_pose({16'd0, 16'd0, 16'sh4000}, {16'd0, 16'sh4000, 16'd0},
                   {16'sh4000, 16'd0, 16'd0}, {21'd256, -21'sd2048, 21'd1536},
                   {32'd31957, 32'd31957}, {16'd3840, 16'd5120}, 16'h0100);
        write_register(UNUSED_REG, '1);
        send_pixel(pack_pixel(12'd320, 12'd240, 16'd1024, 16'h0100, 24'h000000), 1'b1);
        send_pixel(pack_pixel(12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF), 1'b1);
        send_pixel(pack_pixel(12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 24'hA5A5A5), 1'b1);
        send_pixel(pack_pixel(12'd4095, 12'd0, 16'd1, 16'h0100, 24'h5A5A5A), 1'b1);
        send_pixel(pack_pixel(12'd320, 12'd240, 16'd0, 16'hFFFF, 24'h111111), 1'b1);
        send_pixel(pack_pixel(12'd320, 12'd240, 16'd1024, 16'h00FF, 24'h222222), 1'b1);
        send_pixel(pack_pixel(12'd320, 12'd240, 16'd1024, 16'hFFFF, 24'h333333), 1'b0);
        send_pixel(pack_pixel(12'd100, 12'd3000, 16'd2048, 16'h8000, 24'h123456), 1'b1);
        wait_for_points();

        // Largest reciprocals around a centered principal point: on-axis pixels stay
        // inside the world bound, far ones go past it on either side.
        write_pose({16'd0, 16'd0, 16'sh4000}, {16'd0, 16'sh4000, 16'd0},
                   {16'sh4000, 16'd0, 16'd0}, '0, '1, {16'h8000, 16'h8000}, 16'h0000);
        send_pixel(pack_pixel(12'd2048, 12'd2048, 16'hFFFF, 16'd0, 24'h010203), 1'b1);
        send_pixel(pack_pixel(12'd2049, 12'd2048, 16'd1, 16'd0, 24'h040506), 1'b1);
        send_pixel(pack_pixel(12'd4095, 12'd2048, 16'hFFFF, 16'd0, 24'h070809), 1'b1);
        send_pixel(pack_pixel(12'd0, 12'd2048, 16'hFFFF, 16'd0, 24'h0A0B0C), 1'b1);
        send_pixel(pack_pixel(12'd2048, 12'd0, 16'hFFFF, 16'd0, 24'h0D0E0F), 1'b1);
        wait_for_points();

        // Every register bit set: only full confidence passes the threshold.
        write_pose('1, '1, '1, '1, '1, '1, '1);
        send_pixel(pack_pixel(12'd4095, 12'd4095, 16'd1, 16'hFFFF, 24'hC0FFEE), 1'b1);
        send_pixel(pack_pixel(12'd4095, 12'd4095, 16'd1, 16'hFFFE, 24'hBADBAD), 1'b1);
        send_pixel(pack_pixel(12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 24'h777777), 1'b1);

        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_points();
            random_pose(phase == 1 || phase == 4);
            steady_flow = (phase == 2);
            repeat (PHASE_PIXELS)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_for_points();
                send_random_pixel();
            end
        end
        steady_flow = 1'b0;
        wait_for_points();

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
